// ===== rtl/ugas_pkg.sv =====
// Shared types, codes and constants of the undirected graph adjacency store.
package ugas_pkg;

  // Default number of vertex ids kept in the store.
  localparam int unsigned MaxVerticesDef = 64;

  // Field widths of the request and result items.
  localparam int unsigned KindW    = 4;
  localparam int unsigned VertexW  = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InTdataW  = 16;
  localparam int unsigned OutTdataW = 8;

  // Operation codes carried in the request kind field.
  typedef enum logic [KindW-1:0] {
    OpAddV       = 4'd0,
    OpAddE       = 4'd1,
    OpDelV       = 4'd2,
    OpDelE       = 4'd3,
    OpComplete   = 4'd4,
    OpComplement = 4'd5,
    OpClear      = 4'd6,
    OpHasV       = 4'd7,
    OpHasE       = 4'd8,
    OpRelabel    = 4'd9
  } op_e;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusLoop    = 2'd1;
  localparam logic [StatusW-1:0] StatusCollide = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    StIdle,
    StFetch,
    StDecide,
    StSweep,
    StDrain,
    StResp
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_op;
    logic fetch;
    logic capture;
    logic cnt_clr;
    logic sweep_rd;
    logic commit;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_sweep;
    logic last_row;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/undirected_graph_adjacency_store.sv =====
// Top level of the undirected graph adjacency store.
//
// Requests enter on the s_axis channel: tuser carries the operation kind and
// tdata the two vertex ids. Every request produces exactly one result on the
// m_axis channel, carrying a status code and a found flag.
// The block works on one request at a time. Operations that touch only the
// presence vector or read one row (add vertex, add edge with equal endpoints,
// clear edges, has vertex, has edge, refused ones) pass from acceptance through
// the fetch, decide and response states before the next request can be accepted.
// Operations that rewrite rows (add edge, remove vertex, remove edge, complete,
// complement, relabel) also sweep the adjacency memory one row per cycle through
// its single read and write port, followed by a drain state.
// The result is held in an output register, and the next request is accepted
// while it waits; if the receiver stalls, a finished result waits in the
// datapath's result register until the output register is free, and no further
// request is taken meanwhile.
// Reset clears the presence vector and the row valid bits at once, so the
// whole graph reads as empty in the first cycle after reset; no clearing pass
// is needed.
module undirected_graph_adjacency_store #(
  parameter int unsigned MAX_VERTICES = ugas_pkg::MaxVerticesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: vertex_a [5:0], vertex_b [11:6], zero padding [15:12]
  input  logic [ugas_pkg::InTdataW-1:0]     s_axis_tdata,
  // tuser: kind [3:0]
  input  logic [ugas_pkg::KindW-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: status [1:0], found [2], zero padding [7:3]
  output logic [ugas_pkg::OutTdataW-1:0]    m_axis_tdata
);

  ugas_pkg::ctrl_cmd_t          cmd;
  ugas_pkg::dp_stat_t           stat;
  logic [ugas_pkg::StatusW-1:0] out_status;
  logic                         out_found;

  // Sequencing of one request.
  ugas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Graph storage and row updates.
  ugas_dpath #(
    .MaxVertices (MAX_VERTICES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (s_axis_tuser),
    .vertex_a_i   (s_axis_tdata[ugas_pkg::VertexW-1:0]),
    .vertex_b_i   (s_axis_tdata[2*ugas_pkg::VertexW-1:ugas_pkg::VertexW]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_found_o  (out_found)
  );

  // Pack the result fields from the lowest bit up.
  assign m_axis_tdata = ugas_pkg::OutTdataW'({out_found, out_status});

endmodule

// ===== rtl/ugas_ctrl.sv =====
// Controller state machine of the undirected graph adjacency store.
module ugas_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ugas_pkg::dp_stat_t   stat_i,
  output ugas_pkg::ctrl_cmd_t  cmd_o
);

  ugas_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ugas_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ugas_pkg::StIdle: begin
        if (in_valid_i) state_d = ugas_pkg::StFetch;
      end
      ugas_pkg::StFetch: begin
        state_d = ugas_pkg::StDecide;
      end
      ugas_pkg::StDecide: begin
        state_d = stat_i.need_sweep ? ugas_pkg::StSweep : ugas_pkg::StResp;
      end
      ugas_pkg::StSweep: begin
        if (stat_i.last_row) state_d = ugas_pkg::StDrain;
      end
      ugas_pkg::StDrain: begin
        state_d = ugas_pkg::StResp;
      end
      ugas_pkg::StResp: begin
        if (stat_i.out_free) state_d = ugas_pkg::StIdle;
      end
      default: begin
        state_d = ugas_pkg::StIdle;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ugas_pkg::StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.load_op = in_valid_i;
      end
      ugas_pkg::StFetch: begin
        cmd_o.fetch = 1'b1;
      end
      ugas_pkg::StDecide: begin
        cmd_o.capture = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        cmd_o.commit  = !stat_i.need_sweep;
      end
      ugas_pkg::StSweep: begin
        cmd_o.sweep_rd = 1'b1;
      end
      ugas_pkg::StDrain: begin
        cmd_o.commit = 1'b1;
      end
      ugas_pkg::StResp: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/ugas_dpath.sv =====
// Datapath of the undirected graph adjacency store: presence, row memory and sweep.
module ugas_dpath #(
  parameter int unsigned MaxVertices = ugas_pkg::MaxVerticesDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ugas_pkg::ctrl_cmd_t                  cmd_i,
  output ugas_pkg::dp_stat_t                   stat_o,
  input  logic [ugas_pkg::KindW-1:0]           kind_i,
  input  logic [ugas_pkg::VertexW-1:0]         vertex_a_i,
  input  logic [ugas_pkg::VertexW-1:0]         vertex_b_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [ugas_pkg::StatusW-1:0]         out_status_o,
  output logic                                 out_found_o
);

  localparam int unsigned IdxW  = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int unsigned WideW =
    ((IdxW > ugas_pkg::VertexW) ? IdxW : ugas_pkg::VertexW) + 1;
  localparam logic [IdxW-1:0]  LastRow = IdxW'(MaxVertices - 1);
  localparam logic [WideW-1:0] IdLimit = WideW'(MaxVertices);

  typedef logic [MaxVertices-1:0] row_t;

  // Latched request.
  logic [ugas_pkg::KindW-1:0]   kind_q;
  logic [ugas_pkg::VertexW-1:0] va_q, vb_q;

  // Graph state.
  row_t             present_q, present_d;
  row_t             mem_q [MaxVertices];
  row_t             row_valid_q;

  // Row read port and sweep pipeline.
  row_t             rd_q;
  logic             rd_valid_q;
  row_t             saved_q;
  logic [IdxW-1:0]  cnt_q;
  logic             wr_pend_q;
  logic [IdxW-1:0]  wr_addr_q;

  // Result and output registers.
  logic [ugas_pkg::StatusW-1:0] res_status_q, res_status_d;
  logic                         res_found_q, res_found_d;
  logic                         out_valid_q;
  logic [ugas_pkg::StatusW-1:0] out_status_q;
  logic                         out_found_q;

  logic [WideW-1:0] a_wide, b_wide;
  logic             a_ok, b_ok, ab_ok;
  logic [IdxW-1:0]  a_idx, b_idx;
  row_t             a_hot, b_hot, r_hot;
  logic             pa, pb;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  row_t             rd_row;
  row_t             new_row;
  logic             need_sweep;

  // Id range checks and one-hot masks.
  always_comb begin
    a_wide = WideW'(va_q);
    b_wide = WideW'(vb_q);
    a_ok   = a_wide < IdLimit;
    b_ok   = b_wide < IdLimit;
    ab_ok  = a_ok && b_ok;
    a_idx  = a_ok ? a_wide[IdxW-1:0] : '0;
    b_idx  = b_ok ? b_wide[IdxW-1:0] : '0;
    a_hot  = row_t'(1) << a_idx;
    b_hot  = row_t'(1) << b_idx;
    r_hot  = row_t'(1) << wr_addr_q;
    pa     = present_q[a_idx];
    pb     = present_q[b_idx];
    rd_row = rd_valid_q ? rd_q : '0;
  end

  // Operation decode: row sweep, result and presence update.
  always_comb begin
    need_sweep   = 1'b0;
    res_status_d = ugas_pkg::StatusOk;
    res_found_d  = 1'b0;
    present_d    = present_q;
    unique case (kind_q)
      ugas_pkg::OpAddV: begin
        if (a_ok) present_d = present_q | a_hot;
      end
      ugas_pkg::OpAddE: begin
        if (ab_ok) begin
          present_d = present_q | a_hot | b_hot;
          if (a_idx == b_idx) res_status_d = ugas_pkg::StatusLoop;
          else need_sweep = 1'b1;
        end
      end
      ugas_pkg::OpDelV: begin
        if (a_ok && pa) begin
          need_sweep = 1'b1;
          present_d  = present_q & ~a_hot;
        end
      end
      ugas_pkg::OpDelE: begin
        need_sweep = ab_ok && pa && pb;
      end
      ugas_pkg::OpComplete, ugas_pkg::OpComplement: begin
        need_sweep = 1'b1;
      end
      ugas_pkg::OpHasV: begin
        res_found_d = a_ok && pa;
      end
      ugas_pkg::OpHasE: begin
        res_found_d = ab_ok && pa && rd_row[b_idx];
      end
      ugas_pkg::OpRelabel: begin
        if (ab_ok) begin
          if (pb) begin
            res_status_d = ugas_pkg::StatusCollide;
          end else begin
            need_sweep = 1'b1;
            present_d  = (present_q & ~a_hot) | b_hot;
          end
        end
      end
      default: begin
        need_sweep = 1'b0;
      end
    endcase
  end

  // New value of the row that the sweep is writing back.
  always_comb begin
    new_row = rd_row;
    case (kind_q)
      ugas_pkg::OpAddE: begin
        if (wr_addr_q == a_idx) new_row = new_row | b_hot;
        if (wr_addr_q == b_idx) new_row = new_row | a_hot;
      end
      ugas_pkg::OpDelV: begin
        new_row = (wr_addr_q == a_idx) ? '0 : (rd_row & ~a_hot);
      end
      ugas_pkg::OpDelE: begin
        if (wr_addr_q == a_idx) new_row = new_row & ~b_hot;
        if (wr_addr_q == b_idx) new_row = new_row & ~a_hot;
      end
      ugas_pkg::OpComplete: begin
        if (present_q[wr_addr_q]) new_row = present_q & ~r_hot;
      end
      ugas_pkg::OpComplement: begin
        if (present_q[wr_addr_q]) new_row = present_q & ~rd_row & ~r_hot;
      end
      ugas_pkg::OpRelabel: begin
        if (wr_addr_q == b_idx) begin
          new_row = saved_q;
        end else if (wr_addr_q == a_idx) begin
          new_row = '0;
        end else if (saved_q[wr_addr_q]) begin
          new_row = (rd_row & ~a_hot) | b_hot;
        end
      end
      default: begin
        new_row = rd_row;
      end
    endcase
  end

  assign rd_en   = cmd_i.fetch || cmd_i.sweep_rd;
  assign rd_addr = cmd_i.fetch ? a_idx : cnt_q;

  // Request latch, captured row and result, payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_op) begin
      kind_q <= kind_i;
      va_q   <= vertex_a_i;
      vb_q   <= vertex_b_i;
    end
    if (cmd_i.capture) begin
      saved_q      <= rd_row;
      res_status_q <= res_status_d;
      res_found_q  <= res_found_d;
    end
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
    end
  end

  // Row memory: one registered read and one write per cycle.
  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem_q[rd_addr];
    if (wr_pend_q) mem_q[wr_addr_q] <= new_row;
  end

  // Presence, row valid bits and sweep control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      cnt_q       <= '0;
      wr_pend_q   <= 1'b0;
      wr_addr_q   <= '0;
    end else begin
      if (cmd_i.commit) begin
        present_q <= present_d;
      end
      if (cmd_i.commit && (kind_q == ugas_pkg::OpClear)) begin
        row_valid_q <= '0;
      end else if (wr_pend_q) begin
        row_valid_q[wr_addr_q] <= 1'b1;
      end
      if (rd_en) rd_valid_q <= row_valid_q[rd_addr];
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.sweep_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end
      wr_pend_q <= cmd_i.sweep_rd;
      if (cmd_i.sweep_rd) wr_addr_q <= cnt_q;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.need_sweep = need_sweep;
  assign stat_o.last_row   = (cnt_q == LastRow);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;

endmodule

// ===== rtl/ugas_sva.sv =====
// Port-level checker of the undirected graph adjacency store and its bind.
module ugas_sva (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ugas_pkg::OutTdataW-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // One request at a time: after acceptance the input closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A new result appears only as the block returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready) && s_axis_tready)
    else $error("result issued outside request completion");

  // A query answer never comes with an error status, and no status beyond a collision is used.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[ugas_pkg::StatusW-1:0] <= ugas_pkg::StatusCollide) &&
      !(m_axis_tdata[ugas_pkg::StatusW] &&
        (m_axis_tdata[ugas_pkg::StatusW-1:0] != ugas_pkg::StatusOk)))
    else $error("inconsistent result fields");

endmodule

bind undirected_graph_adjacency_store ugas_sva u_sva (.*);
